>>> hw/rtl/u16550_pkg.sv
// Shared types and constants for the 16550 UART register block.
`default_nettype none

package u16550_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_RX    = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Register offsets within the eight-byte window
  localparam logic [2:0] REG_RBR_THR = 3'd0;  // DLL when DLAB set
  localparam logic [2:0] REG_IER     = 3'd1;  // DLM when DLAB set
  localparam logic [2:0] REG_IIR_FCR = 3'd2;
  localparam logic [2:0] REG_LCR     = 3'd3;
  localparam logic [2:0] REG_MCR     = 3'd4;
  localparam logic [2:0] REG_LSR     = 3'd5;
  localparam logic [2:0] REG_MSR     = 3'd6;
  localparam logic [2:0] REG_SCR     = 3'd7;

  localparam int unsigned LCR_DLAB = 7;
  localparam int unsigned MCR_OUT2 = 3;
  localparam int unsigned IER_RX   = 0;
  localparam int unsigned IER_TX   = 1;

  localparam logic [7:0] IIR_RX_DATA  = 8'h04;
  localparam logic [7:0] IIR_TX_EMPTY = 8'h02;
  localparam logic [7:0] IIR_NONE     = 8'h01;
  localparam logic [7:0] LSR_BASE     = 8'h60;
  localparam logic [7:0] MSR_FIXED    = 8'hb0;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 24;

  typedef struct packed {
    op_e        op;
    logic [2:0] reg_offset;
    logic [7:0] wdata;
  } item_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_accepted;
    logic       irq;
    logic       irq_changed;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/uart_16550_register_model.sv
// Top level of the 16550 UART register block.
//
//  channel  dir  handshake          payload
//  s_axis   in   tvalid / tready    tuser = op, tdata = reg_offset, wdata
//  m_axis   out  tvalid / tready    tdata = rdata .. irq_changed
//
// One result beat per input beat; a beat enters every cycle while the output side keeps up.
// Each item passes through the input register, then decode and state update into the output register.
// State updates at the edge where an item moves from the input register to the output register.
// A stall on m_axis holds both registers; s_axis then sees tready low once the input register fills.
// Reset clears every UART register, the interrupt level and both valid flags.
`default_nettype none

module uart_16550_register_model
  import u16550_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,  // reg_offset[2:0], wdata[10:3]
  input  wire logic [IN_USER_W-1:0]  s_axis_tuser_i,  // op[1:0]
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o   // rdata[7:0], tx_valid[8],
                                                      // tx_byte[16:9], rx_accepted[17],
                                                      // irq[18], irq_changed[19]
);

  item_t   in_item;
  item_t   item;
  result_t res_comb;
  result_t res;
  logic    fire;
  logic    room;

  assign in_item.op         = op_e'(s_axis_tuser_i);
  assign in_item.reg_offset = s_axis_tdata_i[2:0];
  assign in_item.wdata      = s_axis_tdata_i[10:3];

  u16550_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_item_i  (in_item),
    .out_room_i (room),
    .fire_o     (fire),
    .item_o     (item)
  );

  u16550_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item),
    .res_o  (res_comb)
  );

  u16550_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .res_i       (res_comb),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  assign m_axis_tdata_o = {4'd0, res.irq_changed, res.irq, res.rx_accepted,
                           res.tx_byte, res.tx_valid, res.rdata};

endmodule

`default_nettype wire

>>> hw/rtl/u16550_in_stage.sv
// Input register stage: captures one slave-side beat and hands it to the register file.
`default_nettype none

module u16550_in_stage
  import u16550_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire item_t in_item_i,
  input  wire logic  out_room_i,
  output logic       fire_o,
  output item_t      item_o
);

  logic  vld_q;
  item_t item_q;

  assign fire_o     = vld_q & out_room_i;
  assign in_ready_o = ~vld_q | out_room_i;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/u16550_regs.sv
// UART register file: state registers plus access decode for one item.
`default_nettype none

module u16550_regs
  import u16550_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  fire_i,
  input  wire item_t item_i,
  output result_t    res_o
);

  logic [7:0] ier_q, ier_d;
  logic [7:0] lcr_q, lcr_d;
  logic [7:0] mcr_q, mcr_d;
  logic [7:0] scr_q, scr_d;
  logic [7:0] dll_q, dll_d;
  logic [7:0] dlm_q, dlm_d;
  logic [7:0] rbr_q, rbr_d;
  logic       rx_full_q, rx_full_d;
  logic       txe_q, txe_d;
  logic       irq_q, irq_d;
  logic       dlab;
  logic       rx_src;
  logic       tx_src;

  always_comb begin
    ier_d     = ier_q;
    lcr_d     = lcr_q;
    mcr_d     = mcr_q;
    scr_d     = scr_q;
    dll_d     = dll_q;
    dlm_d     = dlm_q;
    rbr_d     = rbr_q;
    rx_full_d = rx_full_q;
    txe_d     = txe_q;
    res_o     = '0;
    dlab      = lcr_q[LCR_DLAB];
    rx_src    = ier_q[IER_RX] & rx_full_q;
    tx_src    = ier_q[IER_TX] & txe_q;

    unique case (item_i.op)
      OP_READ: begin
        unique case (item_i.reg_offset)
          REG_RBR_THR: begin
            if (dlab) begin
              res_o.rdata = dll_q;
            end else begin
              res_o.rdata = rx_full_q ? rbr_q : 8'h00;
              rx_full_d   = 1'b0;
            end
          end
          REG_IER:     res_o.rdata = dlab ? dlm_q : ier_q;
          REG_IIR_FCR: begin
            // Receive source outranks transmit; reading the TX code acks it
            if (rx_src) begin
              res_o.rdata = IIR_RX_DATA;
            end else if (tx_src) begin
              res_o.rdata = IIR_TX_EMPTY;
              txe_d       = 1'b0;
            end else begin
              res_o.rdata = IIR_NONE;
            end
          end
          REG_LCR:     res_o.rdata = lcr_q;
          REG_MCR:     res_o.rdata = mcr_q;
          REG_LSR:     res_o.rdata = LSR_BASE | {7'd0, rx_full_q};
          REG_MSR:     res_o.rdata = MSR_FIXED;
          REG_SCR:     res_o.rdata = scr_q;
          default:     res_o.rdata = 8'h00;
        endcase
      end
      OP_WRITE: begin
        unique case (item_i.reg_offset)
          REG_RBR_THR: begin
            if (dlab) begin
              dll_d = item_i.wdata;
            end else begin
              res_o.tx_valid = 1'b1;
              res_o.tx_byte  = item_i.wdata;
              txe_d          = 1'b1;
            end
          end
          REG_IER: begin
            if (dlab) begin
              dlm_d = item_i.wdata;
            end else begin
              // Enabling THRE raises the pending flag right away
              if (!ier_q[IER_TX] && item_i.wdata[IER_TX]) begin
                txe_d = 1'b1;
              end
              ier_d = item_i.wdata;
            end
          end
          REG_LCR: lcr_d = item_i.wdata;
          REG_MCR: mcr_d = item_i.wdata;
          REG_SCR: scr_d = item_i.wdata;
          default: ;  // FCR, LSR, MSR writes dropped
        endcase
      end
      OP_RX: begin
        if (!rx_full_q) begin
          rbr_d             = item_i.wdata;
          rx_full_d         = 1'b1;
          res_o.rx_accepted = 1'b1;
        end
      end
      default: ;
    endcase

    irq_d = mcr_d[MCR_OUT2] &
            ((ier_d[IER_RX] & rx_full_d) | (ier_d[IER_TX] & txe_d));
    res_o.irq         = irq_d;
    res_o.irq_changed = irq_d ^ irq_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ier_q     <= '0;
      lcr_q     <= '0;
      mcr_q     <= '0;
      scr_q     <= '0;
      dll_q     <= '0;
      dlm_q     <= '0;
      rbr_q     <= '0;
      rx_full_q <= 1'b0;
      txe_q     <= 1'b0;
      irq_q     <= 1'b0;
    end else if (fire_i) begin
      ier_q     <= ier_d;
      lcr_q     <= lcr_d;
      mcr_q     <= mcr_d;
      scr_q     <= scr_d;
      dll_q     <= dll_d;
      dlm_q     <= dlm_d;
      rbr_q     <= rbr_d;
      rx_full_q <= rx_full_d;
      txe_q     <= txe_d;
      irq_q     <= irq_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/u16550_out_stage.sv
// Output register: holds one result beat until the master side takes it.
`default_nettype none

module u16550_out_stage
  import u16550_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t res_i,
  output logic         room_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output result_t      res_o
);

  logic    vld_q;
  result_t res_q;

  assign room_o      = ~vld_q | out_ready_i;
  assign out_valid_o = vld_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (room_o) begin
      vld_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/u16550_checker.sv
// Port-level checks for the UART register block, bound to the top level.
`default_nettype none

module u16550_checker
  import u16550_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid_i,
  input wire logic                  s_axis_tready_o,
  input wire logic                  m_axis_tvalid_o,
  input wire logic                  m_axis_tready_i,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  logic last_irq_q;
  logic out_beat;
  logic in_beat;

  assign out_beat = m_axis_tvalid_o & m_axis_tready_i;
  assign in_beat  = s_axis_tvalid_i & s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_irq_q <= 1'b0;
    end else if (out_beat) begin
      last_irq_q <= m_axis_tdata_o[18];
    end
  end

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat changed under stall");

  // irq_changed tracks the level shown by the previous beat
  a_irq_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat |-> m_axis_tdata_o[19] == (m_axis_tdata_o[18] ^ last_irq_q))
    else $error("irq_changed inconsistent with irq history");

  // A transmit beat never doubles as an accepted host byte; tx_byte is zero when idle
  a_tx_rx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[8] && m_axis_tdata_o[17]) &&
                        (m_axis_tdata_o[8] || m_axis_tdata_o[16:9] == 8'h00))
    else $error("tx/rx flags inconsistent");

  // With the output free, an accepted beat produces a result once it has passed the input and output registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && !m_axis_tvalid_o && !$past(in_beat) && m_axis_tready_i |=> ##1 m_axis_tvalid_o)
    else $error("result beat missing after accepted input");

endmodule

bind uart_16550_register_model u16550_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire

>>> tb/uart_16550_register_model_checker.sv
// Checker for the 16550 register block: predicts each result beat and compares it.
`timescale 1ns / 100ps

module uart_16550_register_model_checker
  import u16550_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_tvalid_i,
  input  wire logic                  s_tready_i,
  input  wire logic [IN_DATA_W-1:0]  s_tdata_i,   // reg_offset[2:0], wdata[10:3]
  input  wire logic [IN_USER_W-1:0]  s_tuser_i,   // op[1:0]
  input  wire logic                  m_tvalid_i,
  input  wire logic                  m_tready_i,
  input  wire logic [OUT_DATA_W-1:0] m_tdata_i,   // rdata[7:0], tx_valid[8], tx_byte[16:9],
                                                  // rx_accepted[17], irq[18], irq_changed[19]
  output int unsigned                errors_o,
  output int unsigned                outstanding_o,
  output int unsigned                checked_o
);

  localparam int unsigned MAX_PRINTS = 40;

  // Predicted register file
  logic [7:0] ier_q, lcr_q, mcr_q, scr_q, dll_q, dlm_q, rbr_q;
  logic       rbr_full, thre_pend, irq_q;

  result_t    expected_q[$];
  result_t    want;
  result_t    seen;
  item_t      offered;

  assign offered = {s_tuser_i, s_tdata_i[2:0], s_tdata_i[10:3]};
  assign seen    = {m_tdata_i[7:0], m_tdata_i[8], m_tdata_i[16:9], m_tdata_i[17],
                    m_tdata_i[18], m_tdata_i[19]};

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned exp_val);
    if (errors_o < MAX_PRINTS) begin
      $display("[%0t] result beat %0d: %s got 0x%0h, want 0x%0h",
               $realtime, checked_o, what, got, exp_val);
    end
    errors_o++;
  endtask

  // One register access or host byte; updates the predicted registers.
  function automatic result_t uart_regs_step(input item_t it);
    result_t r;
    logic    dlab;
    logic    irq_prev;
    r        = '0;
    dlab     = lcr_q[LCR_DLAB];
    irq_prev = irq_q;
    case (it.op)
      OP_READ: begin
        case (it.reg_offset)
          REG_RBR_THR: begin
            if (dlab) begin
              r.rdata = dll_q;
            end else begin
              r.rdata  = rbr_full ? rbr_q : 8'h00;
              rbr_full = 1'b0;
            end
          end
          REG_IER: r.rdata = dlab ? dlm_q : ier_q;
          REG_IIR_FCR: begin
            if (ier_q[IER_RX] && rbr_full) begin
              r.rdata = IIR_RX_DATA;
            end else if (ier_q[IER_TX] && thre_pend) begin
              r.rdata   = IIR_TX_EMPTY;
              thre_pend = 1'b0;  // reading the THRE id acknowledges it
            end else begin
              r.rdata = IIR_NONE;
            end
          end
          REG_LCR: r.rdata = lcr_q;
          REG_MCR: r.rdata = mcr_q;
          REG_LSR: r.rdata = LSR_BASE | {7'd0, rbr_full};
          REG_MSR: r.rdata = MSR_FIXED;
          default: r.rdata = scr_q;
        endcase
      end
      OP_WRITE: begin
        case (it.reg_offset)
          REG_RBR_THR: begin
            if (dlab) begin
              dll_q = it.wdata;
            end else begin
              r.tx_valid = 1'b1;
              r.tx_byte  = it.wdata;
              thre_pend  = 1'b1;
            end
          end
          REG_IER: begin
            if (dlab) begin
              dlm_q = it.wdata;
            end else begin
              // enabling THRE while it was off raises the pending flag
              if (!ier_q[IER_TX] && it.wdata[IER_TX]) thre_pend = 1'b1;
              ier_q = it.wdata;
            end
          end
          REG_LCR: lcr_q = it.wdata;
          REG_MCR: mcr_q = it.wdata;
          REG_SCR: scr_q = it.wdata;
          default: ;  // FCR, LSR, MSR writes have no effect
        endcase
      end
      OP_RX: begin
        if (!rbr_full) begin
          rbr_q         = it.wdata;
          rbr_full      = 1'b1;
          r.rx_accepted = 1'b1;
        end
      end
      default: ;
    endcase
    irq_q = mcr_q[MCR_OUT2] && ((ier_q[IER_RX] && rbr_full) || (ier_q[IER_TX] && thre_pend));
    r.irq         = irq_q;
    r.irq_changed = irq_q != irq_prev;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ier_q     = '0;
      lcr_q     = '0;
      mcr_q     = '0;
      scr_q     = '0;
      dll_q     = '0;
      dlm_q     = '0;
      rbr_q     = '0;
      rbr_full  = 1'b0;
      thre_pend = 1'b0;
      irq_q     = 1'b0;
      errors_o  = 0;
      expected_q.delete();
      outstanding_o <= 0;
      checked_o     <= 0;
    end else begin
      // results leave only after their beat has passed the input and output registers, so pop first
      if (m_tvalid_i && m_tready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected beat, tdata", m_tdata_i, 0);
        end else begin
          want = expected_q.pop_front();
          if (seen.rdata != want.rdata) report_mismatch("rdata", seen.rdata, want.rdata);
          if (seen.tx_valid != want.tx_valid)
            report_mismatch("tx_valid", seen.tx_valid, want.tx_valid);
          if (seen.tx_byte != want.tx_byte)
            report_mismatch("tx_byte", seen.tx_byte, want.tx_byte);
          if (seen.rx_accepted != want.rx_accepted)
            report_mismatch("rx_accepted", seen.rx_accepted, want.rx_accepted);
          if (seen.irq != want.irq) report_mismatch("irq", seen.irq, want.irq);
          if (seen.irq_changed != want.irq_changed)
            report_mismatch("irq_changed", seen.irq_changed, want.irq_changed);
        end
        checked_o <= checked_o + 1;
      end
      if (s_tvalid_i && s_tready_i) expected_q.push_back(uart_regs_step(offered));
      outstanding_o <= expected_q.size();
    end
  end

endmodule

>>> tb/uart_16550_register_model_tb.sv
// Testbench top for the 16550 register block: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module uart_16550_register_model_tb;
  import u16550_pkg::*;

  localparam int unsigned DIRECTED_BEATS = 25;
  localparam int unsigned RANDOM_BEATS   = 1950;
  localparam int unsigned PHASE_BEATS    = 650;
  localparam int unsigned HOLD_CYCLES    = 80;
  localparam int unsigned LIMIT_CYCLES   = 200000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  s_axis_tvalid;
  wire                   s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // reg_offset[2:0], wdata[10:3]
  logic [IN_USER_W-1:0]  s_axis_tuser;   // op[1:0]
  wire                   m_axis_tvalid;
  logic                  m_axis_tready;
  wire  [OUT_DATA_W-1:0] m_axis_tdata;   // rdata[7:0], tx_valid[8], tx_byte[16:9],
                                         // rx_accepted[17], irq[18], irq_changed[19]

  int unsigned errors, outstanding, checked;
  int unsigned beats_sent = 0;
  int unsigned cycle_cnt = 0;
  int unsigned send_idle_pct = 18;
  int unsigned recv_idle_pct = 46;
  int unsigned next_hold_at = 300;
  int unsigned holds_done = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  uart_16550_register_model uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  uart_16550_register_model_checker checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .s_tuser_i     (s_axis_tuser),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .errors_o      (errors),
    .outstanding_o (outstanding),
    .checked_o     (checked)
  );

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    while (cycle_cnt < LIMIT_CYCLES) @(posedge clk);
    $display("timeout after %0d cycles, %0d results still pending", cycle_cnt, outstanding);
    $display("uart_16550_register_model_tb: FAIL");
    $finish;
  end

  // Output side: random backpressure plus occasional long hold-offs to fill the pipe.
  initial begin : receiver
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (beats_sent >= next_hold_at) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        holds_done++;
        next_hold_at = (holds_done == 1) ? 1500 : 32'hffff_ffff;
      end else begin
        m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  task automatic send_beat(input op_e op, input logic [2:0] off, input logic [7:0] data);
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'd0, data, off};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    beats_sent++;
  endtask

  // Short register-level scenarios with random content, or a single noise beat.
  task automatic send_scenario();
    int unsigned pick;
    op_e         op;
    pick = $urandom_range(99, 0);
    if (pick < 20) begin
      // host byte arrives, software services it; second byte may hit a full RBR
      send_beat(OP_RX, 3'($urandom), 8'($urandom));
      if ($urandom_range(1, 0)) send_beat(OP_RX, 3'($urandom), 8'($urandom));
      send_beat(OP_READ, REG_IIR_FCR, 8'($urandom));
      send_beat(OP_READ, REG_LSR, 8'($urandom));
      send_beat(OP_READ, REG_RBR_THR, 8'($urandom));
    end else if (pick < 32) begin
      // divisor latch programming
      send_beat(OP_WRITE, REG_LCR, {1'b1, 7'($urandom)});
      send_beat(OP_WRITE, REG_RBR_THR, 8'($urandom));
      send_beat(OP_WRITE, REG_IER, 8'($urandom));
      send_beat(OP_READ, $urandom_range(1, 0) ? REG_IER : REG_RBR_THR, 8'($urandom));
      send_beat(OP_WRITE, REG_LCR, {1'b0, 7'($urandom)});
    end else if (pick < 50) begin
      // transmit and check the THRE interrupt
      send_beat(OP_WRITE, REG_RBR_THR, 8'($urandom));
      send_beat(OP_READ, REG_IIR_FCR, 8'($urandom));
      send_beat(OP_READ, REG_LSR, 8'($urandom));
    end else if (pick < 65) begin
      // interrupt setup: OUT2 mostly on
      send_beat(OP_WRITE, REG_MCR, 8'($urandom) | ($urandom_range(4, 0) != 0 ? 8'h08 : 8'h00));
      send_beat(OP_WRITE, REG_IER, 8'($urandom));
      send_beat(OP_READ, REG_IIR_FCR, 8'($urandom));
    end else begin
      op = ($urandom_range(15, 0) == 0) ? OP_NONE : op_e'($urandom_range(2, 0));
      send_beat(op, 3'($urandom), 8'($urandom));
    end
  endtask

  initial begin : stimulus
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = OP_NONE;
    s_axis_tdata  = '0;
    rst_n         = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: reset values, divisor latch, both interrupt sources, ignored writes
    send_beat(OP_READ, REG_IIR_FCR, 8'h00);
    send_beat(OP_READ, REG_MSR, 8'hff);
    send_beat(OP_READ, REG_LSR, 8'h00);
    send_beat(OP_WRITE, REG_LCR, 8'h80);
    send_beat(OP_WRITE, REG_RBR_THR, 8'hff);
    send_beat(OP_WRITE, REG_IER, 8'h00);
    send_beat(OP_READ, REG_RBR_THR, 8'h00);
    send_beat(OP_READ, REG_IER, 8'h00);
    send_beat(OP_WRITE, REG_LCR, 8'h03);
    send_beat(OP_WRITE, REG_MCR, 8'h08);
    send_beat(OP_WRITE, REG_IER, 8'h03);     // THRE pending, irq rises
    send_beat(OP_READ, REG_IIR_FCR, 8'h00);  // acknowledges THRE, irq falls
    send_beat(OP_RX, 3'd7, 8'hff);
    send_beat(OP_RX, 3'd0, 8'h00);           // refused, holding register full
    send_beat(OP_READ, REG_LSR, 8'h00);
    send_beat(OP_READ, REG_IIR_FCR, 8'h00);
    send_beat(OP_READ, REG_RBR_THR, 8'h00);
    send_beat(OP_WRITE, REG_RBR_THR, 8'ha5);
    send_beat(OP_WRITE, REG_IIR_FCR, 8'hc7);
    send_beat(OP_WRITE, REG_LSR, 8'hff);
    send_beat(OP_WRITE, REG_MSR, 8'hff);
    send_beat(OP_WRITE, REG_SCR, 8'hff);
    send_beat(OP_READ, REG_SCR, 8'h00);
    send_beat(OP_NONE, 3'd7, 8'hff);
    send_beat(OP_READ, REG_IER, 8'h00);

    while (beats_sent < DIRECTED_BEATS + RANDOM_BEATS) begin
      if (beats_sent >= DIRECTED_BEATS + 2 * PHASE_BEATS) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (beats_sent >= DIRECTED_BEATS + PHASE_BEATS) begin
        send_idle_pct = 46;
        recv_idle_pct = 18;
      end
      send_scenario();
    end
    s_axis_tvalid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("run covered %0d input beats (directed, register scenarios, noise), %0d results",
             beats_sent, checked);
    $display("idle mixes 18/46, 46/18 and none, with %0d long output hold-offs", holds_done);
    if (errors == 0 && outstanding == 0) begin
      $display("uart_16550_register_model_tb: PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, outstanding);
      $display("uart_16550_register_model_tb: FAIL");
    end
    $finish;
  end

endmodule
